>>> design/pixel_color_adjust_core_assert.svh
`ifndef PIXEL_COLOR_ADJUST_CORE_ASSERT_SVH
`define PIXEL_COLOR_ADJUST_CORE_ASSERT_SVH

// same-cycle implication, checked on clk, off while in reset
`define PCA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pca assertion failed");

// next-cycle implication
`define PCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pca assertion failed");

`endif

>>> design/pca_pkg.sv
package pca_pkg;

  localparam int ChanW    = 8;
  localparam int ModeW    = 3;
  localparam int NumLanes = 3;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic [ModeW-1:0] MODE_GRAY  = 3'd0;
  localparam logic [ModeW-1:0] MODE_RED   = 3'd1;
  localparam logic [ModeW-1:0] MODE_GREEN = 3'd2;
  localparam logic [ModeW-1:0] MODE_BLUE  = 3'd3;
  localparam logic [ModeW-1:0] MODE_HIGH  = 3'd4;
  localparam logic [ModeW-1:0] MODE_LOW   = 3'd5;
  localparam logic [ModeW-1:0] MODE_NEG   = 3'd6;

  // lane order: blue, green, red
  localparam logic [ModeW-1:0] TintMode [NumLanes] = '{MODE_BLUE, MODE_GREEN, MODE_RED};

  localparam logic [ChanW-1:0] MeanThresh = 8'd127;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t in_blue;
    chan_t in_green;
    chan_t in_red;
  } pca_in_t;

  typedef struct packed {
    chan_t out_blue;
    chan_t out_green;
    chan_t out_red;
  } pca_out_t;

  // per-channel candidates found by one lane
  typedef struct packed {
    chan_t orig;
    chan_t tint;
    chan_t hi_up;
    chan_t hi_dn;
    chan_t low;
    chan_t neg;
  } lane_cand_t;

endpackage

>>> design/pixel_color_adjust_core.sv
// Pipeline: from request accept to result valid a pixel passes the lane/mean stage, then the merge stage.
// Throughput: one pixel per clock while in_stall is low; three channel lanes plus a mean unit run in parallel.
// in_stall rises only when both stages hold data and out_stall is high.
// Reset (rst_n, synchronous, active low) clears the pipeline valids and sets mode to gray.
module pixel_color_adjust_core
  import pca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pca_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pca_out_t            out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  logic [ModeW-1:0] mode_r, mode_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             s1_load, s2_load, cfg_wr;

  chan_t      chan_in [NumLanes];
  lane_cand_t cand    [NumLanes];
  chan_t      mean;

  // config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[CfgAddrW-1] ? '0 : {{(CfgDataW-ModeW){1'b0}}, mode_r};

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && !cfg_paddr[CfgAddrW-1]) begin
      mode_nxt = cfg_pwdata[ModeW-1:0];
    end
  end

  // pipeline control
  assign s2_load  = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  always_comb begin
    s1_valid_nxt  = s1_load ? in_valid : s1_valid_r;
    out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GRAY;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign chan_in[0] = in_data.in_blue;
  assign chan_in[1] = in_data.in_green;
  assign chan_in[2] = in_data.in_red;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    pca_lane u_lane (
      .clk  (clk),
      .en   (s1_load && in_valid),
      .chan (chan_in[g]),
      .cand (cand[g])
    );
  end

  pca_mean u_mean (
    .clk  (clk),
    .en   (s1_load && in_valid),
    .pix  (in_data),
    .mean (mean)
  );

  pca_merge u_merge (
    .clk  (clk),
    .en   (s2_load && s1_valid_r),
    .mode (mode_r),
    .mean (mean),
    .cand (cand),
    .pix  (out_data)
  );

  assign out_valid = out_valid_r;

`include "pixel_color_adjust_core_assert.svh"

  `PCA_ASSERT_NOW(a_stall_full, in_stall, s1_valid_r && out_valid_r && out_stall)
  `PCA_ASSERT_NEXT(a_req_enters, in_valid && !in_stall, s1_valid_r)
  `PCA_ASSERT_NEXT(a_s1_moves, s1_valid_r && s2_load, out_valid_r)
  `PCA_ASSERT_NEXT(a_mode_wr, cfg_wr && !cfg_paddr[CfgAddrW-1],
                   mode_r == $past(cfg_pwdata[ModeW-1:0]))

endmodule

>>> design/pca_lane.sv
module pca_lane
  import pca_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  chan_t      chan,
  output lane_cand_t cand
);

  localparam logic [ChanW:0] Sat255  = 9'd255;
  localparam chan_t          LowHi   = 8'd170;
  localparam chan_t          LowMid  = 8'd127;

  lane_cand_t cand_r, cand_nxt;

  logic [ChanW:0]   x1p5, x1p25;
  logic [ChanW+1:0] x3;
  chan_t            x0p75;

  always_comb begin
    x1p5  = {1'b0, chan} + {2'b0, chan[ChanW-1:1]};
    x1p25 = {1'b0, chan} + {3'b0, chan[ChanW-1:2]};
    x3    = {2'b0, chan} + {1'b0, chan, 1'b0};
    x0p75 = x3[ChanW+1:2];

    cand_nxt.orig  = chan;
    cand_nxt.tint  = (x1p5 > Sat255) ? 8'hFF : x1p5[ChanW-1:0];
    cand_nxt.hi_up = (x1p25 > Sat255) ? 8'hFF : x1p25[ChanW-1:0];
    cand_nxt.hi_dn = x0p75;
    cand_nxt.neg   = 8'hFF - chan;
    if (chan >= LowHi) begin
      cand_nxt.low = x0p75;
    end else if (chan >= LowMid) begin
      cand_nxt.low = LowMid;
    end else if (x1p25 > {1'b0, LowMid}) begin
      cand_nxt.low = LowMid;
    end else begin
      cand_nxt.low = x1p25[ChanW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand_r <= cand_nxt;
    end
  end

  assign cand = cand_r;

endmodule

>>> design/pca_mean.sv
module pca_mean
  import pca_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  pca_in_t pix,
  output chan_t   mean
);

  // floor(s/3) == (s*683) >> 11 for every s below 2048
  localparam int SumW      = ChanW + 2;
  localparam int RecipW    = 10;
  localparam int MeanShift = 11;
  localparam logic [RecipW-1:0] MeanRecip = 10'd683;

  logic [SumW-1:0]        sum;
  logic [SumW+RecipW-1:0] prod;
  chan_t                  mean_r;

  always_comb begin
    sum  = {2'b0, pix.in_blue} + {2'b0, pix.in_green} + {2'b0, pix.in_red};
    prod = {{RecipW{1'b0}}, sum} * {{SumW{1'b0}}, MeanRecip};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mean_r <= prod[MeanShift+ChanW-1:MeanShift];
    end
  end

  assign mean = mean_r;

endmodule

>>> design/pca_merge.sv
module pca_merge
  import pca_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [ModeW-1:0] mode,
  input  chan_t            mean,
  input  lane_cand_t       cand [NumLanes],
  output pca_out_t         pix
);

  chan_t    res [NumLanes];
  logic     mean_hi;
  pca_out_t pix_r, pix_nxt;

  always_comb begin
    mean_hi = (mean > MeanThresh);
    for (int i = 0; i < NumLanes; i++) begin
      case (mode) inside
        MODE_GRAY:                       res[i] = mean;
        MODE_RED, MODE_GREEN, MODE_BLUE: res[i] = (mode == TintMode[i]) ? cand[i].tint
                                                                          : cand[i].orig;
        MODE_HIGH:                       res[i] = mean_hi ? cand[i].hi_up : cand[i].hi_dn;
        MODE_LOW:                        res[i] = cand[i].low;
        MODE_NEG:                        res[i] = cand[i].neg;
        default:                         res[i] = cand[i].orig;
      endcase
    end
    pix_nxt.out_blue  = res[0];
    pix_nxt.out_green = res[1];
    pix_nxt.out_red   = res[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix = pix_r;

endmodule
